// ===== hw/rtl/ttce_pkg.sv =====
`default_nettype none

package ttce_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);

  // Field widths fixed by the port list.
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  // Control characters.
  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_VT  = 8'h0b;
  localparam logic [CHAR_W-1:0] CH_FF  = 8'h0c;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0d;

  localparam logic [COL_W-1:0] TAB_MASK = 7'h07;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_ATTRIBUTE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_VIDEO = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IGNORE_CR     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CR_TO_NL      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_NL_NO_ADVANCE = 3'd4;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_ERASE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_EXEC,
    ST_ERASE,
    ST_READ,
    ST_MOVE,
    ST_BLANK,
    ST_DONE
  } state_t;

  // Line discipline modes that steer the character decoder.
  typedef struct packed {
    logic ignore_cr;
    logic cr_to_newline;
    logic newline_no_advance;
  } modes_t;

  // What one put-character operation does to the cursor and the store.
  typedef struct packed {
    logic             write_cell;
    logic             beep;
    logic             advance;
    logic [COL_W-1:0] new_col;
  } put_ctl_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/text_terminal_char_engine.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// command   in         start & !busy          op, char_code, erase_count, read_col, read_row
// result    out        done (one cycle)       cursor_col, cursor_row, cursor_index,
//                                             cell_data, beep
// config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// A put or any command that finishes at once goes from the execute state to the done
// strobe, a read inside the screen through the read state first; erase back blanks the
// erased cells one at a time; clear screen sweeps all 2000 cells of the 80 x 25 store; a
// scroll then copies every row but the top one up a row, its read running a cell ahead of
// the copy, and blanks the bottom row. busy stays high through the done cycle, so the next
// transfer can be accepted in the cycle after it. This work runs through the single write
// port of the screen store and the shared sweep counter that walks it.
// After reset a clearing pass fills the whole store with blanks; busy is high
// throughout and configuration transfers are taken as ever.
// The result is presented for exactly one cycle; the receiver cannot stall it.

module text_terminal_char_engine (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Command channel.
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          op,
  input  wire logic [ttce_pkg::CHAR_W-1:0]         char_code,
  input  wire logic [ttce_pkg::COL_W-1:0]          erase_count,
  input  wire logic [ttce_pkg::COL_W-1:0]          read_col,
  input  wire logic [ttce_pkg::ROW_W-1:0]          read_row,
  // Result channel.
  output logic                                     done,
  output logic [ttce_pkg::COL_W-1:0]               cursor_col,
  output logic [ttce_pkg::ROW_W-1:0]               cursor_row,
  output logic [ttce_pkg::IDX_W-1:0]               cursor_index,
  output logic [ttce_pkg::CELL_W-1:0]              cell_data,
  output logic                                     beep,
  // Configuration channel.
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ttce_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [ttce_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ttce_pkg::*;

  // The scroll copy reads one row ahead of where it writes; this is its last count.
  localparam logic [ADDR_W-1:0] MOVE_LAST = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] SWEEP_END = ADDR_W'(CELLS - 1);

  // Configuration registers.
  logic [ATTR_W-1:0] attribute;
  logic              reverse_video;
  logic              ignore_cr;
  logic              cr_to_newline;
  logic              newline_no_advance;

  // Sequencer and cursor.
  state_t            state;
  state_t            state_next;
  logic [COL_W-1:0]  cursor_q;
  logic [ROW_W-1:0]  row_q;
  logic [ADDR_W-1:0] sweep;
  logic [COL_W-1:0]  erase_left;
  logic [ATTR_W-1:0] fill_attr;
  logic              fill_report;

  // Captured command.
  op_t               op_q;
  logic [CHAR_W-1:0] char_q;
  logic [COL_W-1:0]  count_q;
  logic [COL_W-1:0]  rc_q;
  logic [ROW_W-1:0]  rr_q;

  // Screen store, one write and one registered read per cycle.
  logic [CELL_W-1:0] mem [CELLS];
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] rdata;

  logic [ATTR_W-1:0] eff_attr;
  logic [ADDR_W-1:0] cur_addr;
  logic [COL_W-1:0]  erase_n;
  logic              read_ok;
  logic              need_scroll;
  logic              accept;
  modes_t            modes;
  put_ctl_t          put_ctl;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign done      = (state == ST_DONE);

  // Reverse video swaps the foreground and background nibbles.
  assign eff_attr = reverse_video ? {attribute[3:0], attribute[7:4]} : attribute;
  assign cur_addr = cell_addr(row_q, cursor_q);

  // The erase count never reaches past column zero.
  assign erase_n = (count_q > cursor_q) ? cursor_q : count_q;
  assign read_ok = (int'(rc_q) < COLUMNS) && (int'(rr_q) < ROWS);

  assign modes.ignore_cr          = ignore_cr;
  assign modes.cr_to_newline      = cr_to_newline;
  assign modes.newline_no_advance = newline_no_advance;

  ttce_put_decode u_decode (
    .char_code (char_q),
    .col       (cursor_q),
    .modes     (modes),
    .ctl       (put_ctl)
  );

  // A row advance from the bottom row scrolls the store instead of moving the cursor.
  assign need_scroll = put_ctl.advance && (row_q == ROW_W'(ROWS - 1));

  assign cursor_col   = cursor_q;
  assign cursor_row   = row_q;
  assign cursor_index = IDX_W'(cur_addr);

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      attribute          <= RESET_ATTR;
      reverse_video      <= 1'b0;
      ignore_cr          <= 1'b0;
      cr_to_newline      <= 1'b0;
      newline_no_advance <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ATTRIBUTE:     attribute          <= cfg_data;
        CFG_REVERSE_VIDEO: reverse_video      <= cfg_data[0];
        CFG_IGNORE_CR:     ignore_cr          <= cfg_data[0];
        CFG_CR_TO_NL:      cr_to_newline      <= cfg_data[0];
        CFG_NL_NO_ADVANCE: newline_no_advance <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_FILL: begin
        if (sweep == SWEEP_END) begin
          state_next = fill_report ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (op_q)
          OP_PUT:   state_next = need_scroll ? ST_MOVE : ST_DONE;
          OP_ERASE: state_next = (erase_n == '0) ? ST_DONE : ST_ERASE;
          OP_CLEAR: state_next = ST_FILL;
          OP_READ:  state_next = read_ok ? ST_READ : ST_DONE;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_ERASE: begin
        if (erase_left == COL_W'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: state_next = ST_DONE;
      ST_MOVE: begin
        if (sweep == MOVE_LAST) begin
          state_next = ST_BLANK;
        end
      end
      ST_BLANK: begin
        if (sweep == SWEEP_END) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Store port control for each state.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (state)
      ST_FILL: begin
        we    = 1'b1;
        waddr = sweep;
        wdata = {fill_attr, BLANK_CHAR};
      end
      ST_EXEC: begin
        if (op_q == OP_PUT) begin
          we    = put_ctl.write_cell;
          waddr = cur_addr;
          wdata = {eff_attr, char_q};
        end
        if (op_q == OP_READ && read_ok) begin
          raddr = cell_addr(rr_q, rc_q);
        end
      end
      ST_ERASE: begin
        we    = 1'b1;
        waddr = cur_addr - ADDR_W'(1);
        wdata = {eff_attr, BLANK_CHAR};
      end
      ST_MOVE: begin
        // Each cell read here lands one row higher in the following cycle.
        we    = (sweep != '0);
        waddr = sweep - ADDR_W'(1);
        wdata = rdata;
        if (sweep < MOVE_LAST) begin
          raddr = sweep + ADDR_W'(COLUMNS);
        end
      end
      ST_BLANK: begin
        we    = 1'b1;
        waddr = sweep;
        wdata = {eff_attr, BLANK_CHAR};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_FILL;
      sweep       <= '0;
      fill_attr   <= RESET_ATTR;
      fill_report <= 1'b0;
      cursor_q    <= '0;
      row_q       <= '0;
      erase_left  <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_FILL: begin
          sweep <= (sweep == SWEEP_END) ? '0 : sweep + ADDR_W'(1);
        end
        ST_EXEC: begin
          sweep <= '0;
          case (op_q)
            OP_PUT: begin
              cursor_q <= put_ctl.new_col;
              if (put_ctl.advance && !need_scroll) begin
                row_q <= row_q + ROW_W'(1);
              end
            end
            OP_ERASE: erase_left <= erase_n;
            OP_CLEAR: begin
              fill_attr   <= attribute;
              fill_report <= 1'b1;
            end
            default: begin
            end
          endcase
        end
        ST_ERASE: begin
          cursor_q   <= cursor_q - COL_W'(1);
          erase_left <= erase_left - COL_W'(1);
        end
        // The copy ends on the first cell of the bottom row, where the blanking starts.
        ST_MOVE: begin
          if (sweep != MOVE_LAST) begin
            sweep <= sweep + ADDR_W'(1);
          end
        end
        ST_BLANK: sweep <= sweep + ADDR_W'(1);
        default: begin
        end
      endcase
    end
  end

  // Command capture and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= op_t'(op);
      char_q    <= char_code;
      count_q   <= erase_count;
      rc_q      <= read_col;
      rr_q      <= read_row;
      cell_data <= '0;
      beep      <= 1'b0;
    end else begin
      if (state == ST_EXEC && op_q == OP_PUT) begin
        beep <= put_ctl.beep;
      end
      if (state == ST_READ) begin
        cell_data <= rdata;
      end
    end
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted command did not raise busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done strobe without work in progress");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    int'(cursor_q) < COLUMNS)
    else $error("cursor column out of range");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (int'(waddr) < CELLS))
    else $error("store write address out of range");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ttce_put_decode.sv =====
`default_nettype none

module ttce_put_decode (
  input  wire logic [ttce_pkg::CHAR_W-1:0] char_code,
  input  wire logic [ttce_pkg::COL_W-1:0]  col,
  input  wire ttce_pkg::modes_t            modes,
  output ttce_pkg::put_ctl_t               ctl
);
  import ttce_pkg::*;

  logic [COL_W:0] step;

  always_comb begin
    ctl         = '0;
    ctl.new_col = col;
    step        = '0;
    case (char_code)
      CH_NUL: begin
      end
      CH_BEL: begin
        ctl.beep = 1'b1;
      end
      CH_LF: begin
        ctl.new_col = '0;
        ctl.advance = !modes.newline_no_advance;
      end
      CH_VT, CH_FF: begin
        ctl.advance = 1'b1;
      end
      CH_CR: begin
        if (!modes.ignore_cr) begin
          ctl.new_col = '0;
          ctl.advance = modes.cr_to_newline;
        end
      end
      CH_TAB: begin
        step = {1'b0, col | TAB_MASK} + (COL_W+1)'(1);
        if (step >= (COL_W+1)'(COLUMNS)) begin
          ctl.new_col = '0;
          ctl.advance = 1'b1;
        end else begin
          ctl.new_col = step[COL_W-1:0];
        end
      end
      default: begin
        ctl.write_cell = 1'b1;
        step = {1'b0, col} + (COL_W+1)'(1);
        if (step >= (COL_W+1)'(COLUMNS)) begin
          ctl.new_col = '0;
          ctl.advance = 1'b1;
        end else begin
          ctl.new_col = step[COL_W-1:0];
        end
      end
    endcase
  end

endmodule

`default_nettype wire
